/* rtl/pbi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_pkg - palette brightness / invert shared definitions
// beat types, command codes and the per-channel arithmetic
// ----------------------------------------------------------------------------
package pbi_pkg;

    // command codes
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_BRIGHT = 2'd1;
    localparam logic [1:0] FUNC_INVERT = 2'd2;

    localparam int CNT_W       = 7;            // holds 0..127, passes clip it to 64 entries
    localparam int MAX_RESULTS = 64;
    localparam logic [CNT_W-1:0] COLORS_RESET = 7'd64;

    localparam logic signed [12:0] CH_MAX      = 13'sd2047;
    localparam logic signed [12:0] CH_MIN      = -13'sd2048;
    localparam logic signed [12:0] WHITE_LEVEL = 13'sd255;
    localparam logic [5:0]         DAC_MAX     = 6'd63;

    typedef logic signed [11:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pal_entry_t;

    localparam int PAL_W = $bits(pal_entry_t);

    typedef struct packed {
        logic [1:0]        func;
        logic [5:0]        entry_index;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic signed [7:0] change;
    } cmd_beat_t;

    typedef struct packed {
        logic [5:0] entry_out;
        logic [5:0] red_dac;
        logic [5:0] green_dac;
        logic [5:0] blue_dac;
        logic       last;
    } dac_beat_t;

    typedef logic [CNT_W-1:0] cfg_beat_t;

    // brightness step or reflection, saturated to 12 bits
    function automatic chan_t upd_chan(input chan_t v, input logic signed [7:0] chg,
                                       input logic inv);
        logic signed [12:0] s;
        chan_t              r;
        if (inv)
            s = WHITE_LEVEL - 13'(v);
        else
            s = 13'(v) + 13'(chg);
        if (s > CH_MAX)
            r = CH_MAX[11:0];
        else if (s < CH_MIN)
            r = CH_MIN[11:0];
        else
            r = s[11:0];
        return r;
    endfunction

    // v*63/255 with clamping; x/255 as (x + x>>8 + 1) >> 8 for x below 2^14
    function automatic logic [5:0] to_dac(input chan_t v);
        logic [13:0] x;
        logic [15:0] q;
        logic [5:0]  r;
        x = ({6'd0, v[7:0]} << 6) - {6'd0, v[7:0]};
        q = {2'd0, x} + {10'd0, x[13:8]} + 16'd1;
        if (13'(v) > WHITE_LEVEL)
            r = DAC_MAX;
        else if (v < 12'sd0)
            r = 6'd0;
        else
            r = q[13:8];
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/pbi_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_if - valid/ready channels of the palette block
// command, dac result and configuration channels
// ----------------------------------------------------------------------------
interface pbi_cmd_if import pbi_pkg::*; ();
    logic      valid;
    logic      ready;
    cmd_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pbi_dac_if import pbi_pkg::*; ();
    logic      valid;
    logic      ready;
    dac_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pbi_cfg_if import pbi_pkg::*; ();
    logic      valid;
    logic      ready;
    cfg_beat_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/palette_brightness_invert_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palette_brightness_invert_top - extended-range palette with dac output
// palette ram of signed 12-bit rgb channels; load, brightness and invert
// commands; unless a brightness step is refused, one dac beat per used entry for brightness and invert
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | beat contents
//  --------+-----+---------------+---------------------------------------------
//  cfg     | in  | valid / ready | colors_used (7 bits)
//  cmd     | in  | valid / ready | func, entry_index, red/green/blue_in, change
//  dac     | out | valid / ready | entry_out, red/green/blue_dac, last
//
//  load is written from idle; invert runs one read-modify-write pass over the
//  used entries, brightness a counting read pass first (no update if refused);
//  each pass takes one entry per cycle through the single ram read port
//  reset clears control state and sets colors_used to 64; the ram is not
//  cleared, an entry reads as written
//  a stalled dac beat holds the update pass; the ram read data is held with it
//  cmd is taken only while no pass is running; cfg is always ready
// ----------------------------------------------------------------------------
module palette_brightness_invert_top import pbi_pkg::*; #(
    parameter int PALETTE_ENTRIES = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    pbi_cfg_if.sink  cfg,
    pbi_cmd_if.sink  cmd,
    pbi_dac_if.source dac
);

    localparam int AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int LIMIT = (PALETTE_ENTRIES < MAX_RESULTS) ? PALETTE_ENTRIES : MAX_RESULTS;
    localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(LIMIT);

    // sequencer codes
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_COUNT  = 2'd1;    // saturation scan before brightness
    localparam logic [1:0] ST_UPDATE = 2'd2;    // read-modify-write and emit

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  colors_used_reg;
    logic [CNT_W-1:0]  n_reg, n_next;            // entries of the running pass
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;  // next entry to read
    logic              pend_reg, pend_next;      // ram read data is valid
    logic [CNT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic              white_reg, white_next;
    logic              black_reg, black_next;
    logic signed [7:0] change_reg, change_next;
    logic              invert_reg, invert_next;
    logic              dac_valid_reg, dac_valid_next;
    dac_beat_t         dac_data_reg, dac_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    pal_entry_t        ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [PAL_W-1:0]  ram_rdata;

    pal_entry_t        rd_entry;
    pal_entry_t        new_entry;
    logic              cmd_take;
    logic [CNT_W-1:0]  n_cmd;
    logic              rd_more;
    logic              dac_free;
    logic              adv;
    logic              load_ok;
    logic              refused;
    logic              ent_white;
    logic              ent_black;

    pbi_ram #(
        .WIDTH (PAL_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshakes
    assign cfg.ready = 1'b1;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;
    assign dac.valid = dac_valid_reg;
    assign dac.data  = dac_data_reg;

    // used entries, clipped to the palette size and the result limit
    assign n_cmd = (colors_used_reg > LIMIT_CNT) ? LIMIT_CNT : colors_used_reg;

    assign rd_more  = (rd_cnt_reg < n_reg);
    assign dac_free = !dac_valid_reg || dac.ready;
    // one entry leaves the update pass: written back and pushed to the dac register
    assign adv      = (state_reg == ST_UPDATE) && pend_reg && dac_free;

    // the counting pass streams freely, the update pass advances with the output
    assign ram_re    = rd_more && ((state_reg == ST_COUNT)
                       || ((state_reg == ST_UPDATE) && (!pend_reg || adv)));
    assign ram_raddr = AW'(rd_cnt_reg);

    assign rd_entry = ram_rdata;

    assign new_entry.red   = upd_chan(rd_entry.red,   change_reg, invert_reg);
    assign new_entry.green = upd_chan(rd_entry.green, change_reg, invert_reg);
    assign new_entry.blue  = upd_chan(rd_entry.blue,  change_reg, invert_reg);

    // saturation scan of one entry
    assign ent_white = (13'(rd_entry.red) >= WHITE_LEVEL)
                    && (13'(rd_entry.green) >= WHITE_LEVEL)
                    && (13'(rd_entry.blue) >= WHITE_LEVEL);
    assign ent_black = (rd_entry.red <= 12'sd0) && (rd_entry.green <= 12'sd0)
                    && (rd_entry.blue <= 12'sd0);

    // refused when everything is already pinned in the direction of the step
    assign refused = (white_reg && !change_reg[7] && (change_reg != 8'sd0))
                  || (black_reg && change_reg[7]);

    // loads beyond the palette are dropped
    assign load_ok = (int'(cmd.data.entry_index) < PALETTE_ENTRIES);

    // ram write: a load from idle, or the write-back of the update pass
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(pend_idx_reg);
        ram_wdata = new_entry;
        if (cmd_take && (cmd.data.func == FUNC_LOAD) && load_ok)
        begin
            ram_we          = 1'b1;
            ram_waddr       = AW'(cmd.data.entry_index);
            ram_wdata.red   = chan_t'({4'd0, cmd.data.red_in});
            ram_wdata.green = chan_t'({4'd0, cmd.data.green_in});
            ram_wdata.blue  = chan_t'({4'd0, cmd.data.blue_in});
        end
        else if (adv)
        begin
            ram_we = 1'b1;
        end
    end

    // sequencer and pass counters
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        white_next     = white_reg;
        black_next     = black_reg;
        change_next    = change_reg;
        invert_next    = invert_reg;
        dac_valid_next = dac_valid_reg;
        dac_data_next  = dac_data_reg;

        // read pipeline: one read in flight at most
        if (ram_re)
        begin
            rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
            pend_next     = 1'b1;
            pend_idx_next = rd_cnt_reg;
        end
        else if (adv || (state_reg == ST_COUNT))
        begin
            pend_next = 1'b0;
        end

        // output register
        if (adv)
        begin
            dac_valid_next          = 1'b1;
            dac_data_next.entry_out = pend_idx_reg[5:0];
            dac_data_next.red_dac   = to_dac(new_entry.red);
            dac_data_next.green_dac = to_dac(new_entry.green);
            dac_data_next.blue_dac  = to_dac(new_entry.blue);
            dac_data_next.last      = (pend_idx_reg == (n_reg - CNT_W'(1)));
        end
        else if (dac.ready)
        begin
            dac_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take && (n_cmd != '0))
                begin
                    n_next      = n_cmd;
                    rd_cnt_next = '0;
                    pend_next   = 1'b0;
                    change_next = cmd.data.change;
                    unique case (cmd.data.func)
                        FUNC_BRIGHT:
                        begin
                            state_next  = ST_COUNT;
                            invert_next = 1'b0;
                            white_next  = 1'b1;
                            black_next  = 1'b1;
                        end
                        FUNC_INVERT:
                        begin
                            state_next  = ST_UPDATE;
                            invert_next = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_COUNT:
            begin
                if (pend_reg)
                begin
                    white_next = white_reg && ent_white;
                    black_next = black_reg && ent_black;
                end
                if (!rd_more && !pend_reg)
                begin
                    rd_cnt_next = '0;
                    state_next  = refused ? ST_IDLE : ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!rd_more && !pend_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            colors_used_reg <= COLORS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            colors_used_reg <= cfg.data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            n_reg         <= '0;
            pend_reg      <= 1'b0;
            dac_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            n_reg         <= n_next;
            pend_reg      <= pend_next;
            dac_valid_reg <= dac_valid_next;
        end
    end

    // payload and per-pass scratch, no reset
    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        white_reg    <= white_next;
        black_reg    <= black_next;
        change_reg   <= change_next;
        invert_reg   <= invert_next;
        dac_data_reg <= dac_data_next;
    end

    // the counting pass only reads the palette
    a_count_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COUNT) |-> !ram_we)
        else $error("palette written during counting pass");

    // the entry in flight is one of the used entries
    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && pend_reg) |-> (pend_idx_reg < n_reg))
        else $error("entry in flight beyond used count");

    // read pointer never runs past the pass length
    a_rd_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rd_cnt_reg <= n_reg))
        else $error("read pointer past used count");

    // a dac beat only starts from the update pass
    a_dac_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dac_valid_reg) |-> ($past(state_reg) == ST_UPDATE))
        else $error("dac beat raised outside update pass");

    // after the last entry leaves, nothing is left to read or write back
    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && dac_data_next.last) |=> ((state_reg == ST_UPDATE) && !pend_reg && !rd_more))
        else $error("update pass not drained after last entry");

endmodule
`default_nettype wire

/* rtl/pbi_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pbi_ram - generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module pbi_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* tb/palette_brightness_invert_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_brightness_invert_top_tb - self-checking bench for the palette block
// drives load, brightness, invert and unused commands over several colour
// counts, predicts every dac beat from a shadow palette and compares them in
// order, with bursty commands, a stalling dac receiver and a long hold-off
// ----------------------------------------------------------------------------
module palette_brightness_invert_top_tb import pbi_pkg::*; ();

    localparam int PAL_N       = 64;
    localparam int IDLE_GAP    = 2 * PAL_N + 16;   // longest pass with no dac beat
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    // func value with no command behind it
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef enum int {RX_STREAM, RX_HALF, RX_SPARSE} rx_mode_t;

    // one row of the directed sequence; -1 marks a value left to the shadow palette
    typedef struct {
        logic [1:0] op;
        int         idx;
        int         red;
        int         green;
        int         blue;
        int         chg;
        int         n_exp;
        int         dac_all;
    } step_t;

    logic clk;
    logic rst_n;

    pbi_cfg_if cfg_bus ();
    pbi_cmd_if cmd_bus ();
    pbi_dac_if dac_bus ();

    palette_brightness_invert_top #(
        .PALETTE_ENTRIES(PAL_N)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .cmd   (cmd_bus),
        .dac   (dac_bus)
    );

    // shadow palette and the colour count it is working with
    chan_t            shade [PAL_N][3];
    logic [CNT_W-1:0] colors_reg;
    dac_beat_t        pending_dac [$];

    // typed-in expectations of the current directed row
    int row_n_exp;
    int row_dac_all;

    // stimulus bookkeeping: entries that hold a written value
    bit   loaded [PAL_N];
    int   burst_left;
    int   hold_left;
    int   errors;
    int   cycle_count;
    step_t plan [0:23];

    // receiver pattern
    rx_mode_t rx_mode;
    int       rx_left;

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // shadow palette
    // ------------------------------------------------------------------------

    function automatic int clamp_chan(input int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    function automatic logic [5:0] dac_level(input int v);
        if (v > 255)
            return 6'd63;
        if (v < 0)
            return 6'd0;
        return 6'(v * 63 / 255);
    endfunction

    // updates the shadow palette for one accepted command and queues its dac beats
    task automatic apply_palette_cmd(input cmd_beat_t b);
        int        n;
        int        v;
        int        delta;
        int        made;
        bit        all_white;
        bit        all_black;
        dac_beat_t r;
        n = (colors_reg > PAL_N) ? PAL_N : int'(colors_reg);
        made = 0;
        case (b.func)
            FUNC_LOAD:
            begin
                if (b.entry_index < PAL_N)
                begin
                    shade[b.entry_index][0] = chan_t'({4'd0, b.red_in});
                    shade[b.entry_index][1] = chan_t'({4'd0, b.green_in});
                    shade[b.entry_index][2] = chan_t'({4'd0, b.blue_in});
                end
            end
            FUNC_BRIGHT, FUNC_INVERT:
            begin
                delta = $signed(b.change);
                all_white = 1'b1;
                all_black = 1'b1;
                for (int i = 0; i < n; i++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        v = shade[i][c];
                        if (v < 255)
                            all_white = 1'b0;
                        if (v > 0)
                            all_black = 1'b0;
                    end
                end
                // brightness is refused when it would push a saturated palette further
                if (b.func == FUNC_INVERT ||
                    !((all_white && delta > 0) || (all_black && delta < 0)))
                begin
                    for (int i = 0; i < n; i++)
                    begin
                        for (int c = 0; c < 3; c++)
                        begin
                            v = shade[i][c];
                            v = (b.func == FUNC_INVERT) ? 255 - v : v + delta;
                            shade[i][c] = chan_t'(clamp_chan(v));
                        end
                        r.entry_out = 6'(i);
                        r.red_dac   = dac_level(shade[i][0]);
                        r.green_dac = dac_level(shade[i][1]);
                        r.blue_dac  = dac_level(shade[i][2]);
                        r.last      = (i == n - 1);
                        pending_dac.push_back(r);
                        if (row_dac_all >= 0 && (r.red_dac != row_dac_all ||
                            r.green_dac != row_dac_all || r.blue_dac != row_dac_all))
                        begin
                            $error("row dac level: expected %0d, got %0d/%0d/%0d",
                                   row_dac_all, r.red_dac, r.green_dac, r.blue_dac);
                            errors++;
                        end
                    end
                    made = n;
                end
            end
            default:
            begin
            end
        endcase
        if (row_n_exp >= 0 && made != row_n_exp)
        begin
            $error("row beat count: expected %0d, got %0d", row_n_exp, made);
            errors++;
        end
    endtask

    task automatic check_field(input string name, input logic [5:0] want,
                               input logic [5:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // monitor: everything is sampled at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // a dac beat at this edge always belongs to an earlier command
            if (dac_bus.valid && dac_bus.ready)
            begin
                if (pending_dac.size() == 0)
                begin
                    $error("dac beat with nothing expected: entry_out %0d",
                           dac_bus.data.entry_out);
                    errors++;
                end
                else
                begin
                    check_field("entry_out", pending_dac[0].entry_out, dac_bus.data.entry_out);
                    check_field("red_dac", pending_dac[0].red_dac, dac_bus.data.red_dac);
                    check_field("green_dac", pending_dac[0].green_dac, dac_bus.data.green_dac);
                    check_field("blue_dac", pending_dac[0].blue_dac, dac_bus.data.blue_dac);
                    check_field("last", pending_dac[0].last, dac_bus.data.last);
                    void'(pending_dac.pop_front());
                end
            end
            if (cfg_bus.valid && cfg_bus.ready)
                colors_reg = cfg_bus.data;
            if (cmd_bus.valid && cmd_bus.ready)
                apply_palette_cmd(cmd_bus.data);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // dac receiver: a long hold-off on request, otherwise a changing stall pattern
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            dac_bus.ready <= 1'b0;
            hold_left--;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 2));
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            case (rx_mode)
                RX_STREAM: dac_bus.ready <= 1'b1;
                RX_HALF:   dac_bus.ready <= 1'($urandom_range(0, 1));
                default:   dac_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one command beat; commands come in bursts with random gaps between them
    // returns at the accepting edge so a following beat keeps valid high
    task automatic send_cmd(input cmd_beat_t b, input int n_exp, input int dac_all);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
            burst_left = $urandom_range(1, 12);
            repeat (gap)
            begin
                @(negedge clk);
                cmd_bus.valid <= 1'b0;
            end
        end
        @(negedge clk);
        cmd_bus.valid <= 1'b1;
        cmd_bus.data  <= b;
        row_n_exp   = n_exp;
        row_dac_all = dac_all;
        if (b.func == FUNC_LOAD)
            loaded[b.entry_index] = 1'b1;
        do
            @(posedge clk);
        while (!cmd_bus.ready);
        burst_left--;
    endtask

    // sender stops until every queued dac beat has come back
    task automatic pause_until_drained();
        @(negedge clk);
        cmd_bus.valid <= 1'b0;
        while (pending_dac.size() != 0)
            @(negedge clk);
    endtask

    // colour count is only written with the block idle; a refused brightness
    // may still be counting after the last beat, hence the extra gap
    task automatic write_colors(input int v);
        pause_until_drained();
        repeat (IDLE_GAP)
            @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.data  <= cfg_beat_t'(v);
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [7:0] chan_value();
        if ($urandom_range(0, 4) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    function automatic cmd_beat_t noise_beat();
        cmd_beat_t b;
        b.func        = 2'($urandom);
        b.entry_index = 6'($urandom);
        b.red_in      = chan_value();
        b.green_in    = chan_value();
        b.blue_in     = chan_value();
        b.change      = 8'($urandom);
        return b;
    endfunction

    // every used entry must hold a written value before a pass reads it
    task automatic fill_palette(input int n);
        cmd_beat_t b;
        for (int i = 0; i < n; i++)
        begin
            if (!loaded[i])
            begin
                b = noise_beat();
                b.func = FUNC_LOAD;
                b.entry_index = 6'(i);
                send_cmd(b, -1, -1);
            end
        end
    endtask

    task automatic random_phase(input int count, input int n);
        cmd_beat_t b;
        int        pick;
        int        run_len;
        int        step;
        bit        up;
        for (int k = 0; k < count; k++)
        begin
            b = noise_beat();
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // saturation run: same-sign steps drive channels to the 12-bit rails
                run_len = $urandom_range(4, 18);
                up = 1'($urandom_range(0, 1));
                repeat (run_len)
                begin
                    step = $urandom_range(0, 20);
                    b.func = ($urandom_range(0, 9) == 0) ? FUNC_INVERT : FUNC_BRIGHT;
                    b.change = 8'(up ? 127 - step : step - 128);
                    send_cmd(b, -1, -1);
                end
            end
            else
            begin
                if (pick < 40)
                begin
                    b.func = FUNC_LOAD;
                    if (n > 0 && $urandom_range(0, 4) != 0)
                        b.entry_index = 6'($urandom_range(0, n - 1));
                end
                else if (pick < 78)
                begin
                    b.func = FUNC_BRIGHT;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        case ($urandom_range(0, 4))
                            0:       b.change = -8'sd128;
                            1:       b.change = -8'sd1;
                            2:       b.change = 8'sd0;
                            3:       b.change = 8'sd1;
                            default: b.change = 8'sd127;
                        endcase
                    end
                end
                else if (pick < 94)
                    b.func = FUNC_INVERT;
                else
                    b.func = FUNC_NONE;
                send_cmd(b, -1, -1);
            end
        end
    endtask

    initial
    begin
        cmd_beat_t b;
        int        setting [6];
        int        n;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.data  = '0;
        cmd_bus.valid = 1'b0;
        cmd_bus.data  = '0;
        dac_bus.ready = 1'b0;
        colors_reg  = COLORS_RESET;
        row_n_exp   = -1;
        row_dac_all = -1;
        burst_left  = 0;
        hold_left   = 0;
        errors      = 0;
        cycle_count = 0;
        rx_mode     = RX_STREAM;
        rx_left     = 0;

        // directed rows, run with three entries in use
        plan = '{
            // all entries black: darker steps are refused, zero change is not
            '{FUNC_LOAD,    0,   0,   0,   0,    0, 0, -1},
            '{FUNC_LOAD,    1,   0,   0,   0,    0, 0, -1},
            '{FUNC_LOAD,    2,   0,   0,   0,    0, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,   -1, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0, -128, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,    0, 3,  0},
            // reflected to full white: brighter steps are refused
            '{FUNC_INVERT,  0,   0,   0,   0,    0, 3, 63},
            '{FUNC_BRIGHT,  0,   0,   0,   0,    1, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,  127, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,    0, 3, 63},
            '{FUNC_BRIGHT,  0,   0,   0,   0, -128, 3, 31},
            '{FUNC_BRIGHT,  0,   0,   0,   0,  127, 3, 62},
            // above white clamps high, its reflection below zero clamps low
            '{FUNC_BRIGHT,  0,   0,   0,   0,  127, 3, 63},
            '{FUNC_INVERT,  0,   0,   0,   0,    0, 3,  0},
            '{FUNC_LOAD,    0, 255,   0, 128,    0, 0, -1},
            '{FUNC_LOAD,    1,   1, 254, 127,    0, 0, -1},
            '{FUNC_LOAD,    2, 200,  85, 170,    0, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,    0, 3, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,   -1, 3, -1},
            '{FUNC_INVERT,  0,   0,   0,   0,    0, 3, -1},
            // unused command code with every field set
            '{FUNC_NONE,   63, 255, 255, 255,   -1, 0, -1},
            // top entry lies outside the used range
            '{FUNC_LOAD,   63, 255, 255, 255,    0, 0, -1},
            '{FUNC_BRIGHT,  0,   0,   0,   0,  127, 3, -1},
            '{FUNC_INVERT,  0,   0,   0,   0,    0, 3, -1}
        };

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_colors(3);
        foreach (plan[i])
        begin
            b.func        = plan[i].op;
            b.entry_index = 6'(plan[i].idx);
            b.red_in      = 8'(plan[i].red);
            b.green_in    = 8'(plan[i].green);
            b.blue_in     = 8'(plan[i].blue);
            b.change      = 8'(plan[i].chg);
            send_cmd(b, plan[i].n_exp, plan[i].dac_all);
        end

        // random part over several colour counts: none, more than the palette,
        // one, exactly full, then two random sizes
        setting[0] = 0;
        setting[1] = 127;
        setting[2] = 1;
        setting[3] = PAL_N;
        setting[4] = $urandom_range(2, PAL_N - 1);
        setting[5] = $urandom_range(1, 6);
        foreach (setting[s])
        begin
            write_colors(setting[s]);
            n = (setting[s] > PAL_N) ? PAL_N : setting[s];
            fill_palette(n);
            if (s == 1)
            begin
                // receiver holds off while full passes keep coming, so the
                // update pass stalls and the command channel backs up
                hold_left = HOLD_CYCLES;
                for (int k = 0; k < 5; k++)
                begin
                    b = noise_beat();
                    b.func = (k % 2 == 0) ? FUNC_INVERT : FUNC_BRIGHT;
                    send_cmd(b, -1, -1);
                end
                pause_until_drained();
            end
            random_phase(6, n);
        end

        pause_until_drained();
        repeat (IDLE_GAP)
            @(negedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
